// File: design/bsrb_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the bilinear reflect-border sampler
// no dependencies
package bsrb_pkg;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 11;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_COLS = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_ROWS = 2'd1;

	typedef struct packed {
		logic        cmd;
		logic [9:0]  write_col;
		logic [8:0]  write_row;
		logic [15:0] pixel_value;
		logic [17:0] sample_x;
		logic [16:0] sample_y;
	} req_t;

	typedef struct packed {
		logic [31:0] sample_value;
		logic        out_of_range;
	} rsp_t;

	// one queued operation: a pixel write or a resolved sample
	typedef struct packed {
		logic        cmd;
		logic        out_of_range;
		logic [10:0] col0;
		logic [10:0] col1;
		logic [9:0]  row0;
		logic [9:0]  row1;
		logic [11:0] frac_x;
		logic [11:0] frac_y;
		logic [15:0] pixel_value;
	} qent_t;

endpackage

// File: design/bsrb_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bsrb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/bsrb_front.sv
`timescale 1ns / 1ps
// front end: size registers, beat acceptance, range check and reflect-101 neighbours
// depends on bsrb_pkg
module bsrb_front #(
	parameter int MAX_COLS  = 1024,
	parameter int MAX_ROWS  = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bsrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bsrb_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  bsrb_pkg::req_t                    req,
	input  logic                              q_full,
	output logic                              push,
	output bsrb_pkg::qent_t                   ent
);

	localparam int RESET_COLS = (640 > MAX_COLS) ? MAX_COLS : 640;
	localparam int RESET_ROWS = (480 > MAX_ROWS) ? MAX_ROWS : 480;
	localparam logic [17:0] FMASK_X = 18'((2 ** FRAC_BITS) - 1);
	localparam logic [16:0] FMASK_Y = 17'((2 ** FRAC_BITS) - 1);

	logic [10:0] cols_q;
	logic [9:0]  rows_q;
	logic [10:0] cols_new;
	logic [9:0]  rows_new;
	logic [9:0]  rows_raw;
	logic [17:0] xi;
	logic [16:0] yi;
	logic [10:0] col0;
	logic [10:0] col1;
	logic [11:0] col_inc;
	logic [9:0]  row0;
	logic [9:0]  row1;
	logic [10:0] row_inc;
	logic        oor;
	logic        wr_ok;
	logic        is_wr;

	// size registers hold the effective (clamped) value
	always_comb begin
		rows_raw = cfg_data[9:0];
		cols_new = cfg_data;
		if (cfg_data == '0) begin
			cols_new = 11'd1;
		end else if (32'(cfg_data) > MAX_COLS) begin
			cols_new = 11'(MAX_COLS);
		end
		rows_new = rows_raw;
		if (rows_raw == '0) begin
			rows_new = 10'd1;
		end else if (32'(rows_raw) > MAX_ROWS) begin
			rows_new = 10'(MAX_ROWS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= 11'(RESET_COLS);
			rows_q <= 10'(RESET_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bsrb_pkg::REG_IMAGE_COLS: cols_q <= cols_new;
				bsrb_pkg::REG_IMAGE_ROWS: rows_q <= rows_new;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	// integer position, range check, reflect-101 neighbour
	always_comb begin
		xi      = req.sample_x >> FRAC_BITS;
		yi      = req.sample_y >> FRAC_BITS;
		oor     = (xi >= 18'(cols_q)) || (yi >= 17'(rows_q));
		col0    = xi[10:0];
		row0    = yi[9:0];
		col_inc = 12'(col0) + 12'd1;
		row_inc = 11'(row0) + 11'd1;
		if (col_inc < 12'(cols_q)) begin
			col1 = col_inc[10:0];
		end else if (cols_q == 11'd1) begin
			col1 = '0;
		end else begin
			col1 = cols_q - 11'd2;
		end
		if (row_inc < 11'(rows_q)) begin
			row1 = row_inc[9:0];
		end else if (rows_q == 10'd1) begin
			row1 = '0;
		end else begin
			row1 = rows_q - 10'd2;
		end
	end

	assign is_wr = (req.cmd == bsrb_pkg::CMD_WRITE);
	assign wr_ok = (32'(req.write_col) < MAX_COLS) && (32'(req.write_row) < MAX_ROWS);

	always_comb begin
		ent.cmd          = req.cmd;
		ent.out_of_range = oor;
		ent.col0         = is_wr ? 11'(req.write_col) : col0;
		ent.col1         = col1;
		ent.row0         = is_wr ? 10'(req.write_row) : row0;
		ent.row1         = row1;
		ent.frac_x       = 12'(req.sample_x & FMASK_X);
		ent.frac_y       = 12'(req.sample_y & FMASK_Y);
		ent.pixel_value  = req.pixel_value;
	end

	// writes outside the store are taken and dropped
	assign req_ready = !q_full;
	assign push      = req_valid && req_ready && (!is_wr || wr_ok);

endmodule

// File: design/bsrb_queue.sv
`timescale 1ns / 1ps
// short queue of resolved operations between front and back end
// depends on bsrb_pkg
module bsrb_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  bsrb_pkg::qent_t push_ent,
	output logic            full,
	input  logic            pop,
	output bsrb_pkg::qent_t pop_ent,
	output logic            empty
);

	bsrb_pkg::qent_t                  slot_q [bsrb_pkg::QDEPTH];
	logic [bsrb_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [bsrb_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [bsrb_pkg::QCNT_W-1:0]      count_q;

	assign full    = (count_q == bsrb_pkg::QCNT_W'(bsrb_pkg::QDEPTH));
	assign empty   = (count_q == '0);
	assign pop_ent = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_ent;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue pushed while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n) pop |-> !empty)
		else $error("queue popped while empty");
`endif

endmodule

// File: design/bsrb_back.sv
`timescale 1ns / 1ps
// back end: four parity banks, horizontal and vertical blend, result register
// depends on bsrb_pkg and bsrb_ram
module bsrb_back #(
	parameter int MAX_COLS  = 1024,
	parameter int MAX_ROWS  = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_empty,
	input  bsrb_pkg::qent_t q_ent,
	output logic            pop,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output bsrb_pkg::rsp_t  rsp
);

	localparam int CW         = $clog2(MAX_COLS);
	localparam int RW         = $clog2(MAX_ROWS);
	localparam int HCW        = (CW > 1) ? CW - 1 : 1;
	localparam int HRW        = (RW > 1) ? RW - 1 : 1;
	localparam int AW         = HCW + HRW;
	localparam int BANK_DEPTH = 2 ** AW;
	localparam int ONE_W      = FRAC_BITS + 1;
	localparam int HW         = 16 + FRAC_BITS;
	localparam int SW         = 16 + 2 * FRAC_BITS;
	localparam int XW         = SW + 16;
	localparam int SHL        = (2 * FRAC_BITS <= 16) ? 16 - 2 * FRAC_BITS : 0;
	localparam int SHR        = (2 * FRAC_BITS > 16) ? 2 * FRAC_BITS - 16 : 0;
	localparam logic [ONE_W-1:0] ONE = ONE_W'(2 ** FRAC_BITS);

	function automatic logic [AW-1:0] bank_addr(input logic [10:0] col, input logic [9:0] row);
		logic [11:0] ch;
		logic [10:0] rh;
		ch = 12'(col) >> 1;
		rh = 11'(row) >> 1;
		return {rh[HRW-1:0], ch[HCW-1:0]};
	endfunction

	logic                 adv;
	logic                 is_wr;
	logic                 rsp_valid_q;
	logic [3:0]           we_vec;
	logic [3:0]           re_vec;
	logic [15:0]          bank_rd [4];

	logic                 v_s1;
	logic                 oor_s1;
	logic [1:0]           b00_s1;
	logic [1:0]           b10_s1;
	logic [1:0]           b01_s1;
	logic [1:0]           b11_s1;
	logic [FRAC_BITS-1:0] fx_s1;
	logic [FRAC_BITS-1:0] fy_s1;

	logic                 v_s2;
	logic                 oor_s2;
	logic [HW-1:0]        h0_s2;
	logic [HW-1:0]        h1_s2;
	logic [FRAC_BITS-1:0] fy_s2;

	logic [ONE_W-1:0]     wa0;
	logic [ONE_W-1:0]     wa1;
	logic [ONE_W-1:0]     wc0;
	logic [ONE_W-1:0]     wc1;
	logic [HW:0]          h0_c;
	logic [HW:0]          h1_c;
	logic [SW:0]          sum_c;
	logic [XW-1:0]        scaled;
	bsrb_pkg::rsp_t       rsp_q;

	assign adv   = !rsp_valid_q || rsp_ready;
	assign pop   = !q_empty && adv;
	assign is_wr = (q_ent.cmd == bsrb_pkg::CMD_WRITE);

	// bank index is {row parity, col parity}; x0/x1 and y0/y1 differ in parity
	// except on a one-pixel dimension, where both name the same pixel
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic PX = ((b % 2) == 1);
		localparam logic PY = ((b / 2) == 1);
		logic [10:0] col_sel;
		logic [9:0]  row_sel;

		assign col_sel   = (q_ent.col0[0] == PX) ? q_ent.col0 : q_ent.col1;
		assign row_sel   = (q_ent.row0[0] == PY) ? q_ent.row0 : q_ent.row1;
		assign we_vec[b] = pop && is_wr && (q_ent.col0[0] == PX) && (q_ent.row0[0] == PY);
		assign re_vec[b] = pop && !is_wr;

		bsrb_ram #(
			.WIDTH (16),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (we_vec[b]),
			.waddr (bank_addr(q_ent.col0, q_ent.row0)),
			.wdata (q_ent.pixel_value),
			.re    (re_vec[b]),
			.raddr (bank_addr(col_sel, row_sel)),
			.rdata (bank_rd[b])
		);
	end

	// s1: bank read in flight
	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s1 <= q_ent.out_of_range;
			b00_s1 <= {q_ent.row0[0], q_ent.col0[0]};
			b10_s1 <= {q_ent.row0[0], q_ent.col1[0]};
			b01_s1 <= {q_ent.row1[0], q_ent.col0[0]};
			b11_s1 <= {q_ent.row1[0], q_ent.col1[0]};
			fx_s1  <= q_ent.frac_x[FRAC_BITS-1:0];
			fy_s1  <= q_ent.frac_y[FRAC_BITS-1:0];
		end
	end

	// s2: horizontal blend of both rows
	always_comb begin
		wa1  = ONE_W'(fx_s1);
		wa0  = ONE - wa1;
		h0_c = (HW + 1)'(bank_rd[b00_s1]) * (HW + 1)'(wa0)
			+ (HW + 1)'(bank_rd[b10_s1]) * (HW + 1)'(wa1);
		h1_c = (HW + 1)'(bank_rd[b01_s1]) * (HW + 1)'(wa0)
			+ (HW + 1)'(bank_rd[b11_s1]) * (HW + 1)'(wa1);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oor_s2 <= oor_s1;
			h0_s2  <= h0_c[HW-1:0];
			h1_s2  <= h1_c[HW-1:0];
			fy_s2  <= fy_s1;
		end
	end

	// vertical blend and scaling to 16 fractional bits
	always_comb begin
		wc1    = ONE_W'(fy_s2);
		wc0    = ONE - wc1;
		sum_c  = (SW + 1)'(h0_s2) * (SW + 1)'(wc0) + (SW + 1)'(h1_s2) * (SW + 1)'(wc1);
		scaled = (XW'(sum_c[SW-1:0]) << SHL) >> SHR;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_q.out_of_range <= oor_s2;
			rsp_q.sample_value <= oor_s2 ? 32'd0 : scaled[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= pop && !is_wr;
			v_s2        <= v_s1;
			rsp_valid_q <= v_s2;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_write_one_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_wr) |-> $onehot(we_vec))
		else $error("pixel write must hit exactly one bank");
	a_no_mixed_access: assert property (@(posedge clk) disable iff (!arst_n)
		!((|we_vec) && (|re_vec)))
		else $error("bank write and read in the same cycle");
	a_sample_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !is_wr) ##1 adv ##1 adv |=> rsp_valid_q)
		else $error("sample result missing after three advancing cycles");
`endif

endmodule

// File: design/bilinear_sampler_reflect_border_core.sv
`timescale 1ns / 1ps
// top level of the bilinear reflect-border sampler
// depends on bsrb_pkg, bsrb_front, bsrb_queue, bsrb_back, bsrb_ram
//
// Takes one beat per clock while the queue is not full, writes and samples alike, and keeps
// them in order. A write beat stores one 16-bit pixel and returns nothing; a sample beat passes
// the queue, the bank read, the horizontal blend and the vertical blend into the result
// register before it is offered on the result side. The image sits in four banks split by
// row and column parity, each with one read port, so the four neighbours of a sample are read
// in the same cycle and the sustained rate is one beat per cycle while the result side is not
// stalled. A four-deep queue lets the input side keep going through short stalls of the result
// side. The store is not cleared: a sample must only touch pixels written since reset.
module bilinear_sampler_reflect_border_core #(
	parameter int MAX_COLS  = 1024,
	parameter int MAX_ROWS  = 512,
	parameter int FRAC_BITS = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bsrb_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [bsrb_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  bsrb_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output bsrb_pkg::rsp_t                   rsp
);

	logic            q_push;
	logic            q_full;
	logic            q_pop;
	logic            q_empty;
	bsrb_pkg::qent_t q_in;
	bsrb_pkg::qent_t q_out;

	bsrb_front #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.q_full    (q_full),
		.push      (q_push),
		.ent       (q_in)
	);

	bsrb_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_ent (q_in),
		.full     (q_full),
		.pop      (q_pop),
		.pop_ent  (q_out),
		.empty    (q_empty)
	);

	bsrb_back #(
		.MAX_COLS  (MAX_COLS),
		.MAX_ROWS  (MAX_ROWS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_ent     (q_out),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule
